@@ hdl/assert_macros.svh @@
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SCP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SCP_ASSERT_NOW(lbl, ante, cons)
`define SCP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/scp_pkg.sv @@
package scp_pkg;

	localparam int ARG_MAX    = 12;
	localparam int HEAD_BYTES = 8;
	localparam int TAIL_BYTES = 4;
	localparam int STEP_W     = 4;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_V     = 8'h56;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_U     = 8'h55;

	localparam logic [7:0]  VOL_RESET = 8'd20;
	localparam logic [7:0]  VOL_TOP   = 8'd255;
	localparam logic [15:0] MAG_SAT   = 16'd32768;

	typedef enum logic [1:0] {
		PH_COLON = 2'd0,
		PH_CMD   = 2'd1,
		PH_ARG   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		PEND_STOP  = 3'd0,
		PEND_PLAY  = 3'd1,
		PEND_BEEP  = 3'd2,
		PEND_VOL   = 3'd3,
		PEND_CHDIR = 3'd4,
		PEND_MODE  = 3'd5,
		PEND_PAUSE = 3'd6
	} pend_t;

	typedef enum logic [3:0] {
		EV_NONE     = 4'd0,
		EV_PLAY     = 4'd1,
		EV_STOP     = 4'd2,
		EV_BEEP     = 4'd3,
		EV_CHDIR    = 4'd4,
		EV_VOLUME   = 4'd5,
		EV_MODE     = 4'd6,
		EV_PAUSE    = 4'd7,
		EV_OVERFLOW = 4'd8
	} evt_t;

	typedef enum logic [3:0] {
		U_NOP    = 4'd0,
		U_TAKE   = 4'd1,
		U_CHAR   = 4'd2,
		U_EMIT   = 4'd3,
		U_PINIT  = 4'd4,
		U_INC    = 4'd5,
		U_SIGN   = 4'd6,
		U_DIGIT  = 4'd7,
		U_FINISH = 4'd8
	} uop_t;

	typedef enum logic [2:0] {
		C_NEVER      = 3'd0,
		C_ALWAYS     = 3'd1,
		C_NO_INPUT   = 3'd2,
		C_NEED_PARSE = 3'd3,
		C_OUT_FREE   = 3'd4,
		C_NOT_WS     = 3'd5,
		C_NOT_SIGN   = 3'd6,
		C_NOT_DIGIT  = 3'd7
	} cond_t;

	typedef struct packed {
		uop_t              uop;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic need_parse;
		logic out_free;
		logic not_ws;
		logic not_sign;
		logic not_digit;
	} dp_stat_t;

	localparam logic [STEP_W-1:0] ST_WAIT  = 4'd0;
	localparam logic [STEP_W-1:0] ST_CHAR  = 4'd1;
	localparam logic [STEP_W-1:0] ST_EMIT  = 4'd2;
	localparam logic [STEP_W-1:0] ST_HOLD  = 4'd3;
	localparam logic [STEP_W-1:0] ST_PINIT = 4'd4;
	localparam logic [STEP_W-1:0] ST_SKIPT = 4'd5;
	localparam logic [STEP_W-1:0] ST_SKIP  = 4'd6;
	localparam logic [STEP_W-1:0] ST_SIGNT = 4'd7;
	localparam logic [STEP_W-1:0] ST_SIGN  = 4'd8;
	localparam logic [STEP_W-1:0] ST_DIGT  = 4'd9;
	localparam logic [STEP_W-1:0] ST_DIG   = 4'd10;
	localparam logic [STEP_W-1:0] ST_FIN   = 4'd11;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			ST_WAIT:  w = '{U_TAKE,   C_NO_INPUT,   ST_WAIT};
			ST_CHAR:  w = '{U_CHAR,   C_NEED_PARSE, ST_PINIT};
			ST_EMIT:  w = '{U_EMIT,   C_OUT_FREE,   ST_WAIT};
			ST_HOLD:  w = '{U_NOP,    C_ALWAYS,     ST_EMIT};
			ST_PINIT: w = '{U_PINIT,  C_NEVER,      ST_WAIT};
			ST_SKIPT: w = '{U_NOP,    C_NOT_WS,     ST_SIGNT};
			ST_SKIP:  w = '{U_INC,    C_ALWAYS,     ST_SKIPT};
			ST_SIGNT: w = '{U_NOP,    C_NOT_SIGN,   ST_DIGT};
			ST_SIGN:  w = '{U_SIGN,   C_NEVER,      ST_WAIT};
			ST_DIGT:  w = '{U_NOP,    C_NOT_DIGIT,  ST_FIN};
			ST_DIG:   w = '{U_DIGIT,  C_ALWAYS,     ST_DIGT};
			ST_FIN:   w = '{U_FINISH, C_ALWAYS,     ST_EMIT};
			default:  w = '{U_NOP,    C_ALWAYS,     ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

@@ hdl/serial_command_parser.sv @@
// An ordinary accepted item is latched in the wait step, decoded in the char
// step and registered onto the outputs in the emit step. A newline ending a
// volume or mode line first walks the argument store in the shared parse steps.
// The sequencer takes a new item only in its wait step, after the emit step;
// a stalled result holds the sequencer for as long as the stall lasts.
// Reset: arst_n clears control state, volume to 20, mode to one shot, pause off.
`include "assert_macros.svh"
module serial_command_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  event_res,
	output logic [7:0]  volume_level,
	output logic        play_continuous,
	output logic        paused,
	output logic [63:0] arg_head,
	output logic [31:0] arg_tail,
	output logic [3:0]  arg_length
);
	import scp_pkg::*;

	uop_t     uop;
	dp_stat_t stat;
	logic     no_line_ev;
	logic     args_clear;

	assign in_stall = (uop != U_TAKE);

	assign no_line_ev = (event_res == EV_NONE) || (event_res == EV_OVERFLOW);
	assign args_clear = (arg_head == '0) && (arg_tail == '0) && (arg_length == '0);

	scp_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.uop      (uop)
	);

	scp_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.uop             (uop),
		.in_valid        (in_valid),
		.rx_char         (rx_char),
		.out_stall       (out_stall),
		.stat            (stat),
		.out_valid       (out_valid),
		.event_res       (event_res),
		.volume_level    (volume_level),
		.play_continuous (play_continuous),
		.paused          (paused),
		.arg_head        (arg_head),
		.arg_tail        (arg_tail),
		.arg_length      (arg_length)
	);

	`SCP_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	`SCP_ASSERT_NOW(a_no_arg_without_line, out_valid && no_line_ev, args_clear)
	`SCP_ASSERT_NOW(a_arg_len_range, out_valid, arg_length <= 4'(ARG_MAX) && volume_level != VOL_TOP)

endmodule

@@ hdl/scp_sequencer.sv @@
module scp_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  scp_pkg::dp_stat_t stat,
	output scp_pkg::uop_t     uop
);
	import scp_pkg::*;

	logic [STEP_W-1:0] pc_q;
	ucode_t            word;
	logic              jump;

	assign word = ucode_rom(pc_q);
	assign uop  = word.uop;

	always_comb begin
		case (word.cond)
			C_NEVER:      jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_NO_INPUT:   jump = !in_valid;
			C_NEED_PARSE: jump = stat.need_parse;
			C_OUT_FREE:   jump = stat.out_free;
			C_NOT_WS:     jump = stat.not_ws;
			C_NOT_SIGN:   jump = stat.not_sign;
			C_NOT_DIGIT:  jump = stat.not_digit;
			default:      jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
		end else if (jump) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

@@ hdl/scp_datapath.sv @@
module scp_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  scp_pkg::uop_t     uop,
	input  logic              in_valid,
	input  logic [7:0]        rx_char,
	input  logic              out_stall,
	output scp_pkg::dp_stat_t stat,
	output logic              out_valid,
	output logic [3:0]        event_res,
	output logic [7:0]        volume_level,
	output logic              play_continuous,
	output logic              paused,
	output logic [63:0]       arg_head,
	output logic [31:0]       arg_tail,
	output logic [3:0]        arg_length
);
	import scp_pkg::*;

	logic [7:0]  ch_q;
	phase_t      phase_q;
	pend_t       pend_q;
	logic [3:0]  cnt_q;
	logic [7:0]  store_q [ARG_MAX];
	logic [7:0]  vol_q;
	logic        mode_q;
	logic        pause_q;
	logic [3:0]  idx_q;
	logic        neg_q;
	logic [15:0] mag_q;
	evt_t        res_ev_q;
	logic [63:0] res_head_q;
	logic [31:0] res_tail_q;
	logic [3:0]  res_len_q;
	logic        out_valid_q;
	logic [3:0]  out_ev_q;
	logic [7:0]  out_vol_q;
	logic        out_mode_q;
	logic        out_pause_q;
	logic [63:0] out_head_q;
	logic [31:0] out_tail_q;
	logic [3:0]  out_len_q;

	logic [7:0]  fold;
	logic [7:0]  cur;
	logic        cur_ok;
	logic        out_free;
	logic [19:0] prod;
	logic [63:0] pack_head;
	logic [31:0] pack_tail;

	assign fold = (rx_char >= CH_LOW_A && rx_char <= CH_LOW_Z) ? rx_char - CASE_GAP : rx_char;

	assign cur_ok = idx_q < cnt_q;
	assign cur    = cur_ok ? store_q[idx_q] : 8'h00;

	assign out_free = !out_valid_q || !out_stall;

	assign stat.need_parse = (phase_q == PH_ARG) && (ch_q == CH_LF) &&
		((pend_q == PEND_VOL) || (pend_q == PEND_MODE));
	assign stat.out_free   = out_free;
	assign stat.not_ws     = !(cur_ok && (cur == CH_SPACE || cur == CH_TAB ||
		cur == CH_VT || cur == CH_FF));
	assign stat.not_sign   = !(cur_ok && (cur == CH_PLUS || cur == CH_MINUS));
	assign stat.not_digit  = !(cur_ok && cur >= CH_ZERO && cur <= CH_NINE);

	assign prod = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {16'b0, cur[3:0]};

	always_comb begin
		pack_head = '0;
		pack_tail = '0;
		for (int k = 0; k < HEAD_BYTES; k++) begin
			if (4'(k) < cnt_q) begin
				pack_head[8*k +: 8] = store_q[k];
			end
		end
		for (int k = 0; k < TAIL_BYTES; k++) begin
			if (4'(k + HEAD_BYTES) < cnt_q) begin
				pack_tail[8*k +: 8] = store_q[k + HEAD_BYTES];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (uop == U_CHAR && phase_q == PH_ARG && ch_q != CH_CR && ch_q != CH_LF &&
			cnt_q < 4'(ARG_MAX)) begin
			store_q[cnt_q] <= ch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q       <= '0;
			phase_q    <= PH_COLON;
			pend_q     <= PEND_STOP;
			cnt_q      <= '0;
			vol_q      <= VOL_RESET;
			mode_q     <= 1'b0;
			pause_q    <= 1'b0;
			idx_q      <= '0;
			neg_q      <= 1'b0;
			mag_q      <= '0;
			res_ev_q   <= EV_NONE;
			res_head_q <= '0;
			res_tail_q <= '0;
			res_len_q  <= '0;
		end else begin
			case (uop)
				U_TAKE: begin
					if (in_valid) begin
						ch_q <= fold;
					end
				end
				U_CHAR: begin
					res_ev_q   <= EV_NONE;
					res_head_q <= '0;
					res_tail_q <= '0;
					res_len_q  <= '0;
					case (phase_q)
						PH_CMD: begin
							phase_q <= PH_ARG;
							case (ch_q)
								CH_P:    pend_q <= PEND_PLAY;
								CH_S:    pend_q <= PEND_STOP;
								CH_V:    pend_q <= PEND_VOL;
								CH_B:    pend_q <= PEND_BEEP;
								CH_C:    pend_q <= PEND_CHDIR;
								CH_M:    pend_q <= PEND_MODE;
								CH_U:    pend_q <= PEND_PAUSE;
								default: phase_q <= PH_COLON;
							endcase
						end
						PH_ARG: begin
							if (ch_q == CH_CR) begin
								cnt_q <= cnt_q;
							end else if (ch_q != CH_LF) begin
								if (cnt_q < 4'(ARG_MAX)) begin
									cnt_q <= cnt_q + 1'b1;
								end else begin
									phase_q  <= PH_COLON;
									cnt_q    <= '0;
									res_ev_q <= EV_OVERFLOW;
								end
							end else if (!stat.need_parse) begin
								res_head_q <= pack_head;
								res_tail_q <= pack_tail;
								res_len_q  <= cnt_q;
								case (pend_q)
									PEND_PAUSE: begin
										pause_q  <= !pause_q;
										res_ev_q <= EV_PAUSE;
										pend_q   <= PEND_STOP;
									end
									PEND_PLAY:  res_ev_q <= EV_PLAY;
									PEND_BEEP:  res_ev_q <= EV_BEEP;
									PEND_CHDIR: res_ev_q <= EV_CHDIR;
									default:    res_ev_q <= EV_STOP;
								endcase
								cnt_q   <= '0;
								phase_q <= PH_COLON;
							end
						end
						default: begin
							phase_q <= (ch_q == CH_COLON) ? PH_CMD : PH_COLON;
						end
					endcase
				end
				U_PINIT: begin
					idx_q <= '0;
					neg_q <= 1'b0;
					mag_q <= '0;
				end
				U_INC: begin
					idx_q <= idx_q + 1'b1;
				end
				U_SIGN: begin
					neg_q <= (cur == CH_MINUS);
					idx_q <= idx_q + 1'b1;
				end
				U_DIGIT: begin
					mag_q <= (prod > {4'b0, MAG_SAT}) ? MAG_SAT : prod[15:0];
					idx_q <= idx_q + 1'b1;
				end
				U_FINISH: begin
					res_head_q <= pack_head;
					res_tail_q <= pack_tail;
					res_len_q  <= cnt_q;
					if (pend_q == PEND_VOL) begin
						if (!neg_q && mag_q != '0 && mag_q[15:8] == '0) begin
							vol_q <= VOL_TOP - mag_q[7:0];
						end
						res_ev_q <= EV_VOLUME;
					end else begin
						mode_q   <= (mag_q != '0);
						res_ev_q <= EV_MODE;
					end
					pend_q  <= PEND_STOP;
					cnt_q   <= '0;
					phase_q <= PH_COLON;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uop == U_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uop == U_EMIT && out_free) begin
			out_ev_q    <= res_ev_q;
			out_vol_q   <= vol_q;
			out_mode_q  <= mode_q;
			out_pause_q <= pause_q;
			out_head_q  <= res_head_q;
			out_tail_q  <= res_tail_q;
			out_len_q   <= res_len_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = out_ev_q;
	assign volume_level    = out_vol_q;
	assign play_continuous = out_mode_q;
	assign paused          = out_pause_q;
	assign arg_head        = out_head_q;
	assign arg_tail        = out_tail_q;
	assign arg_length      = out_len_q;

endmodule

@@ dv/tb.sv @@
module tb;
	import scp_pkg::*;

	localparam int LIMIT    = 1000000;
	localparam int N_ITEMS  = 1300;
	localparam int MAX_SHOW = 10;

	typedef struct packed {
		evt_t        ev;
		logic [7:0]  vol;
		logic        cont;
		logic        pause;
		logic [63:0] head;
		logic [31:0] tail;
		logic [3:0]  len;
	} reply_t;

	class line_tracker;
		phase_t     phase;
		pend_t      pend;
		int         count;
		logic [7:0] store [ARG_MAX];
		logic [7:0] vol;
		logic       mode;
		logic       pause;
		reply_t     due_replies[$];
		int         bad;

		function new();
			phase = PH_COLON;
			pend  = PEND_STOP;
			count = 0;
			vol   = VOL_RESET;
			mode  = 1'b0;
			pause = 1'b0;
			bad   = 0;
		endfunction

		function int arg_value();
			int  i;
			int  mag;
			bit  neg;
			i   = 0;
			mag = 0;
			neg = 1'b0;
			while (i < count && (store[i] == CH_SPACE || store[i] == CH_TAB ||
					store[i] == CH_VT || store[i] == CH_FF))
				i++;
			if (i < count && (store[i] == CH_PLUS || store[i] == CH_MINUS)) begin
				neg = (store[i] == CH_MINUS);
				i++;
			end
			while (i < count && store[i] >= CH_ZERO && store[i] <= CH_NINE) begin
				mag = mag * 10 + (int'(store[i]) - int'(CH_ZERO));
				if (mag > 32768)
					mag = 32768;
				i++;
			end
			if (neg)
				return -mag;
			return (mag > 32767) ? 32767 : mag;
		endfunction

		function void note_char(logic [7:0] raw);
			logic [7:0] c;
			reply_t     r;
			int         v;
			c = raw;
			if (c >= CH_LOW_A && c <= CH_LOW_Z)
				c = c - CASE_GAP;
			r    = '0;
			r.ev = EV_NONE;
			case (phase)
				PH_CMD: begin
					phase = PH_ARG;
					case (c)
						CH_P: pend = PEND_PLAY;
						CH_S: pend = PEND_STOP;
						CH_V: pend = PEND_VOL;
						CH_B: pend = PEND_BEEP;
						CH_C: pend = PEND_CHDIR;
						CH_M: pend = PEND_MODE;
						CH_U: pend = PEND_PAUSE;
						default: phase = PH_COLON;
					endcase
				end
				PH_ARG: begin
					if (c == CH_CR) begin
					end else if (c != CH_LF) begin
						if (count < ARG_MAX) begin
							store[count] = c;
							count++;
						end else begin
							phase = PH_COLON;
							count = 0;
							r.ev  = EV_OVERFLOW;
						end
					end else begin
						for (int k = 0; k < count; k++) begin
							if (k < HEAD_BYTES)
								r.head[8*k +: 8] = store[k];
							else
								r.tail[8*(k-HEAD_BYTES) +: 8] = store[k];
						end
						r.len = 4'(count);
						case (pend)
							PEND_VOL: begin
								v = arg_value();
								if (v > 0 && v < 256)
									vol = VOL_TOP - 8'(v);
								r.ev = EV_VOLUME;
								pend = PEND_STOP;
							end
							PEND_MODE: begin
								mode = (arg_value() != 0);
								r.ev = EV_MODE;
								pend = PEND_STOP;
							end
							PEND_PAUSE: begin
								pause = ~pause;
								r.ev  = EV_PAUSE;
								pend  = PEND_STOP;
							end
							PEND_PLAY:  r.ev = EV_PLAY;
							PEND_BEEP:  r.ev = EV_BEEP;
							PEND_CHDIR: r.ev = EV_CHDIR;
							default:    r.ev = EV_STOP;
						endcase
						count = 0;
						phase = PH_COLON;
					end
				end
				default: phase = (c == CH_COLON) ? PH_CMD : PH_COLON;
			endcase
			r.vol   = vol;
			r.cont  = mode;
			r.pause = pause;
			due_replies.push_back(r);
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (due_replies.size() == 0) begin
				bad++;
				if (bad <= MAX_SHOW)
					$display("unexpected result: ev %0d vol %0d cont %b pause %b len %0d",
						got.ev, got.vol, got.cont, got.pause, got.len);
				return;
			end
			want = due_replies.pop_front();
			if (got !== want) begin
				bad++;
				if (bad <= MAX_SHOW) begin
					$display("expected ev %0d vol %0d cont %b pause %b head %h tail %h len %0d",
						want.ev, want.vol, want.cont, want.pause, want.head, want.tail,
						want.len);
					$display("  actual ev %0d vol %0d cont %b pause %b head %h tail %h len %0d",
						got.ev, got.vol, got.cont, got.pause, got.head, got.tail, got.len);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_char;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  event_res;
	logic [7:0]  volume_level;
	logic        play_continuous;
	logic        paused;
	logic [63:0] arg_head;
	logic [31:0] arg_tail;
	logic [3:0]  arg_length;

	line_tracker tracker = new();
	logic [7:0]  line_q[$];
	bit          calm;
	int          sent;
	int          cycles;

	serial_command_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_char(rx_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.volume_level(volume_level),
		.play_continuous(play_continuous),
		.paused(paused),
		.arg_head(arg_head),
		.arg_tail(arg_tail),
		.arg_length(arg_length)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("serial_command_parser: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		reply_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.ev    = evt_t'(event_res);
			got.vol   = volume_level;
			got.cont  = play_continuous;
			got.pause = paused;
			got.head  = arg_head;
			got.tail  = arg_tail;
			got.len   = arg_length;
			tracker.check_reply(got);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = calm ? 0 : pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (1 + (calm ? 8 : pick_gap())) @(posedge clk);
		end
	end

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_char  <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_char(c);
		sent++;
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_char(line_q[i]);
		line_q = {};
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.due_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic void push_text(string s);
		foreach (s[i])
			line_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] arg_byte();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(CH_SPACE, 8'h7E));
	endfunction

	function automatic logic [7:0] cmd_letter();
		logic [7:0] letters [7];
		logic [7:0] c;
		letters = '{CH_P, CH_S, CH_V, CH_B, CH_C, CH_M, CH_U};
		c = letters[$urandom_range(0, 6)];
		if ($urandom_range(0, 1) == 1)
			c = c + CASE_GAP;
		return c;
	endfunction

	function automatic void push_number();
		logic [7:0] blanks [4];
		int         mark;
		int         ws;
		blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
		mark   = line_q.size();
		ws     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (ws)
			line_q.push_back(blanks[$urandom_range(0, 3)]);
		case ($urandom_range(0, 5))
			0: line_q.push_back(CH_PLUS);
			1: line_q.push_back(CH_MINUS);
			default: ;
		endcase
		case ($urandom_range(0, 4))
			0, 1: push_text($sformatf("%0d", $urandom_range(0, 300)));
			2: push_text($sformatf("%0d", $urandom_range(0, 99999)));
			3: push_text($sformatf("%0d", $urandom));
			default: push_text($sformatf("%0d", $urandom_range(1, 255)));
		endcase
		if ($urandom_range(0, 5) == 0)
			line_q.push_back(arg_byte());
		while (line_q.size() - mark > ARG_MAX)
			void'(line_q.pop_back());
	endfunction

	function automatic void build_line();
		logic [7:0] c;
		int         r;
		int         n;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			line_q.push_back(CH_COLON);
			c = cmd_letter();
			line_q.push_back(c);
			if ((c == CH_V || c == CH_M || c == CH_V + CASE_GAP || c == CH_M + CASE_GAP)
					&& $urandom_range(0, 4) != 0) begin
				push_number();
			end else begin
				n = ($urandom_range(0, 3) == 0) ? ARG_MAX : $urandom_range(0, ARG_MAX);
				repeat (n) begin
					if ($urandom_range(0, 15) == 0)
						line_q.push_back(CH_CR);
					line_q.push_back(arg_byte());
				end
			end
			if ($urandom_range(0, 3) == 0)
				line_q.push_back(CH_CR);
			line_q.push_back(CH_LF);
		end else if (r < 80) begin
			line_q.push_back(CH_COLON);
			line_q.push_back(cmd_letter());
			repeat (ARG_MAX + 1) begin
				do
					c = arg_byte();
				while (c == CH_CR || c == CH_LF);
				line_q.push_back(c);
			end
		end else if (r < 90) begin
			line_q.push_back(CH_COLON);
			line_q.push_back(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 3))
				line_q.push_back(arg_byte());
			line_q.push_back(CH_LF);
		end else begin
			repeat ($urandom_range(1, 6))
				line_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin
		int next_switch;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		rx_char  = 8'h00;
		calm     = 1'b0;
		sent     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		line_q.push_back(8'h00);
		line_q.push_back(8'hFF);
		push_text(":p");
		line_q.push_back(CH_LF);
		push_text(":S");
		line_q.push_back(CH_CR);
		line_q.push_back(CH_LF);
		push_text(":v1");
		line_q.push_back(CH_LF);
		push_text(":b");
		line_q.push_back(CH_LF);
		push_text(":c/x");
		line_q.push_back(CH_LF);
		push_text(":m-0");
		line_q.push_back(CH_LF);
		push_text(":U");
		line_q.push_back(CH_LF);
		push_text(":Z");
		push_text(":Cabcdefghijklm");
		send_line();
		drain_results();

		next_switch = sent;
		while (sent < N_ITEMS) begin
			if (sent >= next_switch) begin
				calm = ($urandom_range(0, 3) == 0);
				next_switch = sent + 120;
			end
			if ($urandom_range(0, 39) == 0)
				drain_results();
			build_line();
			send_line();
		end

		in_valid <= 1'b0;
		while (tracker.due_replies.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.bad == 0 && tracker.due_replies.size() == 0)
			$display("serial_command_parser: match");
		else
			$display("serial_command_parser: mismatch");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/scp_pkg.sv
hdl/scp_sequencer.sv
hdl/scp_datapath.sv
hdl/serial_command_parser.sv
dv/tb.sv
